// ===== design/gjk_tri_pkg.sv =====
// Shared types and constants for the GJK triangle region step.
package gjk_tri_pkg;

    // Width of each coordinate field on the input channel
    localparam int COORD_W = 16;
    // Width of each direction component on the result channel
    localparam int DIR_W = 51;
    localparam int REGION_W = 3;
    localparam int RANK_W = 2;

    typedef enum logic [REGION_W-1:0] {
        REG_A        = 3'd0,
        REG_AB       = 3'd1,
        REG_AC       = 3'd2,
        REG_TRI      = 3'd3,
        REG_TRI_SWAP = 3'd4
    } region_t;

    localparam logic [RANK_W-1:0] RANK_POINT = 2'd1;
    localparam logic [RANK_W-1:0] RANK_EDGE  = 2'd2;
    localparam logic [RANK_W-1:0] RANK_TRI   = 2'd3;

endpackage

// ===== design/gjk_tri_in_if.sv =====
// Input channel: the three simplex points A, B and C.
interface gjk_tri_in_if;
    logic valid;
    logic ready;
    logic signed [gjk_tri_pkg::COORD_W-1:0] a_x;
    logic signed [gjk_tri_pkg::COORD_W-1:0] a_y;
    logic signed [gjk_tri_pkg::COORD_W-1:0] a_z;
    logic signed [gjk_tri_pkg::COORD_W-1:0] b_x;
    logic signed [gjk_tri_pkg::COORD_W-1:0] b_y;
    logic signed [gjk_tri_pkg::COORD_W-1:0] b_z;
    logic signed [gjk_tri_pkg::COORD_W-1:0] c_x;
    logic signed [gjk_tri_pkg::COORD_W-1:0] c_y;
    logic signed [gjk_tri_pkg::COORD_W-1:0] c_z;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        output ready
    );
endinterface

// ===== design/gjk_tri_out_if.sv =====
// Result channel: region code, new rank and next search direction.
interface gjk_tri_out_if;
    logic valid;
    logic ready;
    logic [gjk_tri_pkg::REGION_W-1:0]     region;
    logic [gjk_tri_pkg::RANK_W-1:0]       new_rank;
    logic signed [gjk_tri_pkg::DIR_W-1:0] dir_x;
    logic signed [gjk_tri_pkg::DIR_W-1:0] dir_y;
    logic signed [gjk_tri_pkg::DIR_W-1:0] dir_z;

    modport source (
        output valid, region, new_rank, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, region, new_rank, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

// ===== design/gjk_triangle_region_step.sv =====
// Top level: six-stage pipeline for the GJK triangle-case region test.
//
//  channel   modport   transfer when         payload
//  simplex   sink      valid && ready        a_x..c_z, signed COORD_W each
//  result    source    valid && ready        region, new_rank, dir_x/y/z
//
// One item per cycle while result is ready. The depth comes from the two
// exact plane-side tests: each 4x(COORD_BITS+2)-bit product of two dot
// products is built from four partial products in one stage and summed in
// the next.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// A stall on result holds every full stage behind it in the same cycle; empty
// stages keep moving, so bubbles close up and the input stays open while a
// result waits, as long as some stage is empty.
module gjk_triangle_region_step #(
    parameter int COORD_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    gjk_tri_in_if.sink    simplex,
    gjk_tri_out_if.source result
);

    localparam int NS = 6;
    localparam int W  = COORD_BITS;
    localparam int D  = W + 1;            // edge and AO components
    localparam int PW = 2 * D;            // component products
    localparam int DW = PW + 2;           // dot products
    localparam int CW = PW + 1;           // cross product components
    localparam int TW = CW + D;           // cross component times a component
    localparam int SW = TW + 2;           // (AB x AC) . AO
    localparam int XW = (TW + 1 > gjk_tri_pkg::DIR_W) ? TW + 1 : gjk_tri_pkg::DIR_W;
    localparam int LO = DW / 2;
    localparam int HI = DW - LO;
    localparam int QW = 2 * DW;           // exact product of two dot products
    localparam int DRW = gjk_tri_pkg::DIR_W;

    // ---------------------------------------------------------------- control
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] adv;

    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || result.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? simplex.valid : vld_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign simplex.ready = adv[0];

    // ---------------------------------------------------- stage 1: edges, AO
    logic signed [W-1:0] pa [3];
    logic signed [W-1:0] pb [3];
    logic signed [W-1:0] pc [3];

    assign pa[0] = simplex.a_x[W-1:0];
    assign pa[1] = simplex.a_y[W-1:0];
    assign pa[2] = simplex.a_z[W-1:0];
    assign pb[0] = simplex.b_x[W-1:0];
    assign pb[1] = simplex.b_y[W-1:0];
    assign pb[2] = simplex.b_z[W-1:0];
    assign pc[0] = simplex.c_x[W-1:0];
    assign pc[1] = simplex.c_y[W-1:0];
    assign pc[2] = simplex.c_z[W-1:0];

    logic signed [D-1:0] s1_ab_next [3];
    logic signed [D-1:0] s1_ac_next [3];
    logic signed [D-1:0] s1_ao_next [3];
    logic signed [D-1:0] s1_ab_reg [3];
    logic signed [D-1:0] s1_ac_reg [3];
    logic signed [D-1:0] s1_ao_reg [3];

    // ------------------------------------------- stage 2: component products
    logic signed [PW-1:0] s2_abac_next [3];
    logic signed [PW-1:0] s2_acao_next [3];
    logic signed [PW-1:0] s2_abao_next [3];
    logic signed [PW-1:0] s2_acac_next [3];
    logic signed [PW-1:0] s2_abab_next [3];
    logic signed [PW-1:0] s2_nrm_p_next [3];
    logic signed [PW-1:0] s2_nrm_n_next [3];
    logic signed [PW-1:0] s2_abo_p_next [3];
    logic signed [PW-1:0] s2_abo_n_next [3];
    logic signed [PW-1:0] s2_aco_p_next [3];
    logic signed [PW-1:0] s2_aco_n_next [3];
    logic signed [PW-1:0] s2_abac_reg [3];
    logic signed [PW-1:0] s2_acao_reg [3];
    logic signed [PW-1:0] s2_abao_reg [3];
    logic signed [PW-1:0] s2_acac_reg [3];
    logic signed [PW-1:0] s2_abab_reg [3];
    logic signed [PW-1:0] s2_nrm_p_reg [3];
    logic signed [PW-1:0] s2_nrm_n_reg [3];
    logic signed [PW-1:0] s2_abo_p_reg [3];
    logic signed [PW-1:0] s2_abo_n_reg [3];
    logic signed [PW-1:0] s2_aco_p_reg [3];
    logic signed [PW-1:0] s2_aco_n_reg [3];
    logic signed [D-1:0]  s2_ab_reg [3];
    logic signed [D-1:0]  s2_ac_reg [3];
    logic signed [D-1:0]  s2_ao_reg [3];

    // ------------------------------------------------- stage 3: dots, crosses
    logic signed [DW-1:0] s3_abac_next;
    logic signed [DW-1:0] s3_acao_next;
    logic signed [DW-1:0] s3_abao_next;
    logic signed [DW-1:0] s3_acac_next;
    logic signed [DW-1:0] s3_abab_next;
    logic signed [CW-1:0] s3_nrm_next [3];
    logic signed [CW-1:0] s3_abo_next [3];
    logic signed [CW-1:0] s3_aco_next [3];
    logic signed [DW-1:0] s3_abac_reg;
    logic signed [DW-1:0] s3_acao_reg;
    logic signed [DW-1:0] s3_abao_reg;
    logic signed [DW-1:0] s3_acac_reg;
    logic signed [DW-1:0] s3_abab_reg;
    logic signed [CW-1:0] s3_nrm_reg [3];
    logic signed [CW-1:0] s3_abo_reg [3];
    logic signed [CW-1:0] s3_aco_reg [3];
    logic signed [D-1:0]  s3_ab_reg [3];
    logic signed [D-1:0]  s3_ac_reg [3];
    logic signed [D-1:0]  s3_ao_reg [3];

    // ------------------------------------------- stage 4: partial products
    logic signed [DW-1:0] wx [4];
    logic signed [DW-1:0] wy [4];

    logic signed [2*HI-1:0]    s4_hh_next [4];
    logic signed [HI+LO:0]     s4_hl_next [4];
    logic signed [HI+LO:0]     s4_lh_next [4];
    logic        [2*LO-1:0]    s4_ll_next [4];
    logic signed [TW-1:0]      s4_tab_p_next [3];
    logic signed [TW-1:0]      s4_tab_n_next [3];
    logic signed [TW-1:0]      s4_tac_p_next [3];
    logic signed [TW-1:0]      s4_tac_n_next [3];
    logic signed [TW-1:0]      s4_side_next [3];
    logic signed [2*HI-1:0]    s4_hh_reg [4];
    logic signed [HI+LO:0]     s4_hl_reg [4];
    logic signed [HI+LO:0]     s4_lh_reg [4];
    logic        [2*LO-1:0]    s4_ll_reg [4];
    logic signed [TW-1:0]      s4_tab_p_reg [3];
    logic signed [TW-1:0]      s4_tab_n_reg [3];
    logic signed [TW-1:0]      s4_tac_p_reg [3];
    logic signed [TW-1:0]      s4_tac_n_reg [3];
    logic signed [TW-1:0]      s4_side_reg [3];
    logic signed [CW-1:0]      s4_nrm_reg [3];
    logic signed [D-1:0]       s4_ao_reg [3];
    logic                      s4_acao_ge_reg;
    logic                      s4_abao_ge_reg;

    // ----------------------------------- stage 5: wide sums, direction terms
    logic signed [QW-1:0]  s5_p_next [4];
    logic signed [XW-1:0]  tab_full [3];
    logic signed [XW-1:0]  tac_full [3];
    logic signed [XW-1:0]  nrm_full [3];
    logic signed [XW-1:0]  nrm_neg [3];
    logic signed [XW-1:0]  ao_full [3];
    logic signed [SW-1:0]  side_sum;
    logic signed [QW-1:0]  s5_p_reg [4];
    logic signed [DRW-1:0] s5_dab_reg [3];
    logic signed [DRW-1:0] s5_dac_reg [3];
    logic signed [DRW-1:0] s5_dtri_reg [3];
    logic signed [DRW-1:0] s5_dswap_reg [3];
    logic signed [DRW-1:0] s5_dao_reg [3];
    logic                  s5_front_reg;
    logic                  s5_acao_ge_reg;
    logic                  s5_abao_ge_reg;

    // --------------------------------------- stage 6: decide and select
    logic signed [QW:0]             diff_ac;
    logic signed [QW:0]             diff_ab;
    gjk_tri_pkg::region_t           s6_region_next;
    logic [gjk_tri_pkg::RANK_W-1:0] s6_rank_next;
    logic signed [DRW-1:0]          s6_dir_next [3];
    gjk_tri_pkg::region_t           s6_region_reg;
    logic [gjk_tri_pkg::RANK_W-1:0] s6_rank_reg;
    logic signed [DRW-1:0]          s6_dir_reg [3];

    // per-component datapath
    for (genvar g = 0; g < 3; g++)
    begin : g_comp
        localparam int J = (g + 1) % 3;
        localparam int K = (g + 2) % 3;

        assign s1_ab_next[g] = D'(pb[g]) - D'(pa[g]);
        assign s1_ac_next[g] = D'(pc[g]) - D'(pa[g]);
        assign s1_ao_next[g] = D'(0) - D'(pa[g]);

        assign s2_abac_next[g]  = s1_ab_reg[g] * s1_ac_reg[g];
        assign s2_acao_next[g]  = s1_ac_reg[g] * s1_ao_reg[g];
        assign s2_abao_next[g]  = s1_ab_reg[g] * s1_ao_reg[g];
        assign s2_acac_next[g]  = s1_ac_reg[g] * s1_ac_reg[g];
        assign s2_abab_next[g]  = s1_ab_reg[g] * s1_ab_reg[g];
        assign s2_nrm_p_next[g] = s1_ab_reg[J] * s1_ac_reg[K];
        assign s2_nrm_n_next[g] = s1_ab_reg[K] * s1_ac_reg[J];
        assign s2_abo_p_next[g] = s1_ab_reg[J] * s1_ao_reg[K];
        assign s2_abo_n_next[g] = s1_ab_reg[K] * s1_ao_reg[J];
        assign s2_aco_p_next[g] = s1_ac_reg[J] * s1_ao_reg[K];
        assign s2_aco_n_next[g] = s1_ac_reg[K] * s1_ao_reg[J];

        assign s3_nrm_next[g] = CW'(s2_nrm_p_reg[g]) - CW'(s2_nrm_n_reg[g]);
        assign s3_abo_next[g] = CW'(s2_abo_p_reg[g]) - CW'(s2_abo_n_reg[g]);
        assign s3_aco_next[g] = CW'(s2_aco_p_reg[g]) - CW'(s2_aco_n_reg[g]);

        // (E x AO) x E for each edge
        assign s4_tab_p_next[g] = s3_abo_reg[J] * s3_ab_reg[K];
        assign s4_tab_n_next[g] = s3_abo_reg[K] * s3_ab_reg[J];
        assign s4_tac_p_next[g] = s3_aco_reg[J] * s3_ac_reg[K];
        assign s4_tac_n_next[g] = s3_aco_reg[K] * s3_ac_reg[J];
        assign s4_side_next[g]  = s3_nrm_reg[g] * s3_ao_reg[g];

        assign tab_full[g] = XW'(s4_tab_p_reg[g]) - XW'(s4_tab_n_reg[g]);
        assign tac_full[g] = XW'(s4_tac_p_reg[g]) - XW'(s4_tac_n_reg[g]);
        assign nrm_full[g] = XW'(s4_nrm_reg[g]);
        assign nrm_neg[g]  = XW'(0) - nrm_full[g];
        assign ao_full[g]  = XW'(s4_ao_reg[g]);
    end

    assign s3_abac_next = DW'(s2_abac_reg[0]) + DW'(s2_abac_reg[1]) + DW'(s2_abac_reg[2]);
    assign s3_acao_next = DW'(s2_acao_reg[0]) + DW'(s2_acao_reg[1]) + DW'(s2_acao_reg[2]);
    assign s3_abao_next = DW'(s2_abao_reg[0]) + DW'(s2_abao_reg[1]) + DW'(s2_abao_reg[2]);
    assign s3_acac_next = DW'(s2_acac_reg[0]) + DW'(s2_acac_reg[1]) + DW'(s2_acac_reg[2]);
    assign s3_abab_next = DW'(s2_abab_reg[0]) + DW'(s2_abab_reg[1]) + DW'(s2_abab_reg[2]);

    // Plane-side products: (AB.AC)(AC.AO), (AC.AC)(AB.AO), (AB.AC)(AB.AO), (AB.AB)(AC.AO)
    assign wx[0] = s3_abac_reg;
    assign wy[0] = s3_acao_reg;
    assign wx[1] = s3_acac_reg;
    assign wy[1] = s3_abao_reg;
    assign wx[2] = s3_abac_reg;
    assign wy[2] = s3_abao_reg;
    assign wx[3] = s3_abab_reg;
    assign wy[3] = s3_acao_reg;

    for (genvar k = 0; k < 4; k++)
    begin : g_wide
        assign s4_hh_next[k] = $signed(wx[k][DW-1:LO]) * $signed(wy[k][DW-1:LO]);
        assign s4_hl_next[k] = $signed(wx[k][DW-1:LO]) * $signed({1'b0, wy[k][LO-1:0]});
        assign s4_lh_next[k] = $signed({1'b0, wx[k][LO-1:0]}) * $signed(wy[k][DW-1:LO]);
        assign s4_ll_next[k] = wx[k][LO-1:0] * wy[k][LO-1:0];

        assign s5_p_next[k] = (QW'(s4_hh_reg[k]) <<< (2 * LO))
                            + (QW'(s4_hl_reg[k]) <<< LO)
                            + (QW'(s4_lh_reg[k]) <<< LO)
                            + QW'($signed({1'b0, s4_ll_reg[k]}));
    end

    assign side_sum = SW'(s4_side_reg[0]) + SW'(s4_side_reg[1]) + SW'(s4_side_reg[2]);

    assign diff_ac = (QW+1)'(s5_p_reg[0]) - (QW+1)'(s5_p_reg[1]);
    assign diff_ab = (QW+1)'(s5_p_reg[2]) - (QW+1)'(s5_p_reg[3]);

    always_comb
    begin
        if (!diff_ac[QW])
        begin
            if (s5_acao_ge_reg)
            begin
                s6_region_next = gjk_tri_pkg::REG_AC;
                s6_dir_next    = s5_dac_reg;
            end
            else if (s5_abao_ge_reg)
            begin
                s6_region_next = gjk_tri_pkg::REG_AB;
                s6_dir_next    = s5_dab_reg;
            end
            else
            begin
                s6_region_next = gjk_tri_pkg::REG_A;
                s6_dir_next    = s5_dao_reg;
            end
        end
        else if (!diff_ab[QW])
        begin
            if (s5_abao_ge_reg)
            begin
                s6_region_next = gjk_tri_pkg::REG_AB;
                s6_dir_next    = s5_dab_reg;
            end
            else
            begin
                s6_region_next = gjk_tri_pkg::REG_A;
                s6_dir_next    = s5_dao_reg;
            end
        end
        else if (s5_front_reg)
        begin
            s6_region_next = gjk_tri_pkg::REG_TRI;
            s6_dir_next    = s5_dtri_reg;
        end
        else
        begin
            s6_region_next = gjk_tri_pkg::REG_TRI_SWAP;
            s6_dir_next    = s5_dswap_reg;
        end

        case (s6_region_next)
            gjk_tri_pkg::REG_A:  s6_rank_next = gjk_tri_pkg::RANK_POINT;
            gjk_tri_pkg::REG_AB,
            gjk_tri_pkg::REG_AC: s6_rank_next = gjk_tri_pkg::RANK_EDGE;
            default:             s6_rank_next = gjk_tri_pkg::RANK_TRI;
        endcase
    end

    // ---------------------------------------------------- datapath registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_ab_reg <= s1_ab_next;
            s1_ac_reg <= s1_ac_next;
            s1_ao_reg <= s1_ao_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_abac_reg  <= s2_abac_next;
            s2_acao_reg  <= s2_acao_next;
            s2_abao_reg  <= s2_abao_next;
            s2_acac_reg  <= s2_acac_next;
            s2_abab_reg  <= s2_abab_next;
            s2_nrm_p_reg <= s2_nrm_p_next;
            s2_nrm_n_reg <= s2_nrm_n_next;
            s2_abo_p_reg <= s2_abo_p_next;
            s2_abo_n_reg <= s2_abo_n_next;
            s2_aco_p_reg <= s2_aco_p_next;
            s2_aco_n_reg <= s2_aco_n_next;
            s2_ab_reg    <= s1_ab_reg;
            s2_ac_reg    <= s1_ac_reg;
            s2_ao_reg    <= s1_ao_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_abac_reg <= s3_abac_next;
            s3_acao_reg <= s3_acao_next;
            s3_abao_reg <= s3_abao_next;
            s3_acac_reg <= s3_acac_next;
            s3_abab_reg <= s3_abab_next;
            s3_nrm_reg  <= s3_nrm_next;
            s3_abo_reg  <= s3_abo_next;
            s3_aco_reg  <= s3_aco_next;
            s3_ab_reg   <= s2_ab_reg;
            s3_ac_reg   <= s2_ac_reg;
            s3_ao_reg   <= s2_ao_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_hh_reg      <= s4_hh_next;
            s4_hl_reg      <= s4_hl_next;
            s4_lh_reg      <= s4_lh_next;
            s4_ll_reg      <= s4_ll_next;
            s4_tab_p_reg   <= s4_tab_p_next;
            s4_tab_n_reg   <= s4_tab_n_next;
            s4_tac_p_reg   <= s4_tac_p_next;
            s4_tac_n_reg   <= s4_tac_n_next;
            s4_side_reg    <= s4_side_next;
            s4_nrm_reg     <= s3_nrm_reg;
            s4_ao_reg      <= s3_ao_reg;
            s4_acao_ge_reg <= !s3_acao_reg[DW-1];
            s4_abao_ge_reg <= !s3_abao_reg[DW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_p_reg <= s5_p_next;
            for (int i = 0; i < 3; i++)
            begin
                s5_dab_reg[i]   <= tab_full[i][DRW-1:0];
                s5_dac_reg[i]   <= tac_full[i][DRW-1:0];
                s5_dtri_reg[i]  <= nrm_full[i][DRW-1:0];
                s5_dswap_reg[i] <= nrm_neg[i][DRW-1:0];
                s5_dao_reg[i]   <= ao_full[i][DRW-1:0];
            end
            // zero counts as in front of the plane
            s5_front_reg   <= !side_sum[SW-1];
            s5_acao_ge_reg <= s4_acao_ge_reg;
            s5_abao_ge_reg <= s4_abao_ge_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_region_reg <= s6_region_next;
            s6_rank_reg   <= s6_rank_next;
            s6_dir_reg    <= s6_dir_next;
        end
    end

    assign result.valid    = vld_reg[NS-1];
    assign result.region   = s6_region_reg;
    assign result.new_rank = s6_rank_reg;
    assign result.dir_x    = s6_dir_reg[0];
    assign result.dir_y    = s6_dir_reg[1];
    assign result.dir_z    = s6_dir_reg[2];

    // ------------------------------------------------------------ assertions
    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = simplex.valid && simplex.ready;
    assign out_xfer = result.valid && result.ready;

    // rank must follow the region that was chosen
    a_rank_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            (result.region == gjk_tri_pkg::REG_A
                && result.new_rank == gjk_tri_pkg::RANK_POINT)
            || ((result.region == gjk_tri_pkg::REG_AB
                || result.region == gjk_tri_pkg::REG_AC)
                && result.new_rank == gjk_tri_pkg::RANK_EDGE)
            || ((result.region == gjk_tri_pkg::REG_TRI
                || result.region == gjk_tri_pkg::REG_TRI_SWAP)
                && result.new_rank == gjk_tri_pkg::RANK_TRI))
        else $error("rank does not match region");

    // a downstream that takes everything never holds off the input
    a_open_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> simplex.ready)
        else $error("input stalled while result side is ready");

    // items in flight change only by transfers in and out
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            $countones(vld_reg) == $countones($past(vld_reg))
                + int'($past(in_xfer)) - int'($past(out_xfer)))
        else $error("pipeline lost or duplicated an item");

endmodule
